// ===== rtl/mss_pkg.sv =====
// shared types, constants and the noise table of the mic sample serializer
package mss_pkg;

  // store sizes
  localparam int unsigned CAPTURE_DEPTH = 4096;
  localparam int unsigned SAMPLE_DEPTH  = 65536;
  localparam int unsigned NOISE_LEN     = 32;

  // derived widths
  localparam int unsigned POS_W   = $clog2(CAPTURE_DEPTH);
  localparam int unsigned PLAY_W  = $clog2(2 * CAPTURE_DEPTH);
  localparam int unsigned CAP_AW  = PLAY_W;
  localparam int unsigned SAMP_AW = $clog2(SAMPLE_DEPTH);
  localparam int unsigned COUNT_W = SAMP_AW + 1;
  localparam int unsigned BPOS_W  = COUNT_W;
  localparam int unsigned NOISE_AW = $clog2(NOISE_LEN);

  // port widths
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned APB_AW     = 4;
  localparam int unsigned APB_DW     = 32;

  // byte and lfsr constants
  localparam logic [7:0]  SILENCE   = 8'h80;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;
  localparam logic [15:0] LFSR_SEED = 16'h0001;

  // command codes
  typedef enum logic [1:0] {
    CMD_READ    = 2'd0,
    CMD_CAPTURE = 2'd1,
    CMD_LOAD    = 2'd2,
    CMD_RESET   = 2'd3
  } mss_cmd_e;

  // register indexes
  typedef enum logic [1:0] {
    REG_MIC_ENABLED  = 2'd0,
    REG_NOISE_MODE   = 2'd1,
    REG_MOVIE_ACTIVE = 2'd2
  } mss_reg_e;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_RESP  = 3'b100
  } mss_state_e;

  // where the source byte of a read comes from
  typedef enum logic [1:0] {
    SRC_FIXED   = 2'd0,
    SRC_CAPTURE = 2'd1,
    SRC_SAMPLE  = 2'd2
  } mss_src_e;

  typedef struct packed {
    logic mic_enabled;
    logic noise_mode;
    logic movie_active;
  } mss_cfg_t;

  // controller to datapath
  typedef struct packed {
    logic item_go;
    logic clear_run;
    logic resp_go;
  } mss_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic in_read;
    logic in_clear;
    logic clear_last;
    logic out_free;
  } mss_sts_t;

  // fixed button noise pattern
  function automatic logic [7:0] noise_byte(input logic [NOISE_AW-1:0] idx);
    logic [7:0] b;
    unique case (idx)
      5'd0:  b = 8'hFC;
      5'd9:  b = 8'hF5;
      5'd14: b = 8'h8E;
      5'd16: b = 8'hF4;
      5'd17: b = 8'hE1;
      5'd18: b = 8'hBF;
      5'd19: b = 8'h9A;
      5'd20: b = 8'h71;
      5'd21: b = 8'h58;
      5'd22: b = 8'h5B;
      5'd23: b = 8'h5F;
      5'd24: b = 8'h62;
      5'd25: b = 8'hC2;
      5'd26: b = 8'h25;
      5'd27: b = 8'h05;
      5'd28: b = 8'h01;
      5'd29: b = 8'h01;
      5'd30: b = 8'h01;
      5'd31: b = 8'h01;
      default: b = 8'hFF;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/mss_ctrl.sv =====
// controller state machine: clearing sweep, word acceptance, result load
module mss_ctrl import mss_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  mss_sts_t sts_i,
  output logic     in_ready_o,
  output mss_ctl_t ctl_o
);

  mss_state_e state_q, state_d;

  // accept only when idle and the output register is free by next cycle
  assign in_ready_o = (state_q == ST_IDLE) && sts_i.out_free;

  always_comb begin
    state_d         = state_q;
    ctl_o.item_go   = 1'b0;
    ctl_o.clear_run = 1'b0;
    ctl_o.resp_go   = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        ctl_o.clear_run = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i && sts_i.out_free) begin
          ctl_o.item_go = 1'b1;
          if (sts_i.in_read) begin
            state_d = ST_RESP;
          end else if (sts_i.in_clear) begin
            state_d = ST_CLEAR;
          end
        end
      end
      ST_RESP: begin
        ctl_o.resp_go = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // state register, a clearing sweep follows reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/mss_dp.sv =====
// datapath: capture and sample stores, positions, noise sources, output register
module mss_dp import mss_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mss_cfg_t              cfg_i,
  input  mss_ctl_t              ctl_i,
  input  logic [9:0]            in_data_i,
  input  logic [IN_USER_W-1:0]  in_user_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output mss_sts_t              sts_o
);

  localparam logic [COUNT_W-1:0] SampleFull = COUNT_W'(SAMPLE_DEPTH);
  localparam logic [POS_W-1:0]   WposLast   = POS_W'(CAPTURE_DEPTH - 1);
  localparam logic [PLAY_W-1:0]  PposLast   = PLAY_W'(2 * CAPTURE_DEPTH - 1);
  localparam logic [CAP_AW-1:0]  ClearLast  = CAP_AW'(2 * CAPTURE_DEPTH - 1);
  localparam logic [BPOS_W:0]    NoiseLen2  = (BPOS_W + 1)'(2 * NOISE_LEN);

  // input word fields
  mss_cmd_e   cmd;
  logic [7:0] data_byte;
  logic       pressed;
  logic       first;

  assign cmd       = mss_cmd_e'(in_user_i);
  assign data_byte = in_data_i[7:0];
  assign pressed   = in_data_i[8];
  assign first     = in_data_i[9];

  // stores
  logic [7:0] cap_mem [2*CAPTURE_DEPTH];
  logic [7:0] smp_mem [SAMPLE_DEPTH];
  logic [7:0] cap_rdata_q, smp_rdata_q;

  // position and source state
  logic [POS_W-1:0]   wpos_q, wpos_d;
  logic               whalf_q, whalf_d;
  logic [PLAY_W-1:0]  ppos_q, ppos_d;
  logic               phalf_q, phalf_d;
  logic [BPOS_W-1:0]  bpos_q, bpos_d;
  logic [15:0]        lfsr_q, lfsr_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [CAP_AW-1:0]  clr_q, clr_d;

  // read context held into the response cycle
  mss_src_e   sel_q, sel_d;
  logic [7:0] fixed_q, fixed_d;
  logic       parity_q, parity_d;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q;

  // memory port controls
  logic               cap_we, cap_re;
  logic [CAP_AW-1:0]  cap_waddr, cap_raddr;
  logic [7:0]         cap_wdata;
  logic               smp_we, smp_re;
  logic [SAMP_AW-1:0] smp_waddr, smp_raddr;

  // button position arithmetic
  logic              sc_nz;
  logic [BPOS_W:0]   len2;
  logic [BPOS_W-1:0] bp_eff;
  logic [BPOS_W:0]   bp_inc;

  assign sc_nz  = (count_q != '0);
  assign len2   = sc_nz ? {count_q, 1'b0} : NoiseLen2;
  assign bp_eff = ({1'b0, bpos_q} >= len2) ? '0 : bpos_q;
  assign bp_inc = {1'b0, bp_eff} + (BPOS_W + 1)'(1);

  // status toward the controller
  assign sts_o.in_read    = (cmd == CMD_READ);
  assign sts_o.in_clear   = (cmd == CMD_RESET) && cfg_i.mic_enabled;
  assign sts_o.clear_last = (clr_q == ClearLast);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // command execution and next state
  always_comb begin
    wpos_d    = wpos_q;
    whalf_d   = whalf_q;
    ppos_d    = ppos_q;
    phalf_d   = phalf_q;
    bpos_d    = bpos_q;
    lfsr_d    = lfsr_q;
    count_d   = count_q;
    clr_d     = clr_q;
    sel_d     = sel_q;
    fixed_d   = fixed_q;
    parity_d  = parity_q;
    cap_we    = 1'b0;
    cap_waddr = clr_q;
    cap_wdata = SILENCE;
    cap_re    = 1'b0;
    cap_raddr = {phalf_q, ppos_q[PLAY_W-1:1]};
    smp_we    = 1'b0;
    smp_waddr = count_q[SAMP_AW-1:0];
    smp_re    = 1'b0;
    smp_raddr = bp_eff[SAMP_AW:1];

    // silence sweep over the capture store
    if (ctl_i.clear_run) begin
      cap_we = 1'b1;
      clr_d  = sts_o.clear_last ? '0 : clr_q + CAP_AW'(1);
    end

    if (ctl_i.item_go) begin
      unique case (cmd)
        CMD_LOAD: begin
          if (first) begin
            smp_we    = 1'b1;
            smp_waddr = '0;
            count_d   = COUNT_W'(1);
          end else if (count_q < SampleFull) begin
            smp_we  = 1'b1;
            count_d = count_q + COUNT_W'(1);
          end
        end
        CMD_CAPTURE: begin
          if (cfg_i.mic_enabled) begin
            cap_we    = 1'b1;
            cap_waddr = {whalf_q, wpos_q};
            cap_wdata = data_byte;
            if (wpos_q == WposLast) begin
              wpos_d  = '0;
              whalf_d = ~whalf_q;
            end else begin
              wpos_d = wpos_q + POS_W'(1);
            end
          end
        end
        CMD_RESET: begin
          if (cfg_i.mic_enabled) begin
            wpos_d  = '0;
            whalf_d = 1'b0;
            ppos_d  = '0;
            phalf_d = 1'b1;
            bpos_d  = '0;
          end
        end
        CMD_READ: begin
          sel_d    = SRC_FIXED;
          fixed_d  = '0;
          parity_d = 1'b0;
          if (cfg_i.mic_enabled) begin
            parity_d = ppos_q[0];
            if (pressed) begin
              // button source: loaded samples, then table or lfsr
              if (sc_nz) begin
                smp_re = 1'b1;
                sel_d  = SRC_SAMPLE;
              end else if (cfg_i.noise_mode) begin
                fixed_d = lfsr_q[7:0];
                lfsr_d  = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);
              end else begin
                fixed_d = noise_byte(bp_eff[NOISE_AW:1]);
              end
              bpos_d = (bp_inc >= len2) ? '0 : bp_inc[BPOS_W-1:0];
            end else begin
              bpos_d = '0;
              if (cfg_i.movie_active) begin
                fixed_d = SILENCE;
              end else begin
                cap_re = 1'b1;
                sel_d  = SRC_CAPTURE;
              end
            end
            // read position and read side flip
            if (ppos_q == PposLast) begin
              ppos_d  = '0;
              phalf_d = ~phalf_q;
            end else begin
              ppos_d = ppos_q + PLAY_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // capture store ports
  always_ff @(posedge clk_i) begin
    if (cap_we) begin
      cap_mem[cap_waddr] <= cap_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap_re) begin
      cap_rdata_q <= cap_mem[cap_raddr];
    end
  end

  // sample store ports
  always_ff @(posedge clk_i) begin
    if (smp_we) begin
      smp_mem[smp_waddr] <= data_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (smp_re) begin
      smp_rdata_q <= smp_mem[smp_raddr];
    end
  end

  // result assembly in the response cycle
  logic [7:0] src_byte;
  logic [7:0] half_byte;

  always_comb begin
    unique case (sel_q)
      SRC_CAPTURE: src_byte = cap_rdata_q;
      SRC_SAMPLE:  src_byte = smp_rdata_q;
      default:     src_byte = fixed_q;
    endcase
    half_byte = parity_q ? {src_byte[0], 7'b0} : {1'b0, src_byte[7:1]};
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (ctl_i.resp_go) begin
      out_valid_d = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q      <= '0;
      whalf_q     <= 1'b0;
      ppos_q      <= '0;
      phalf_q     <= 1'b1;
      bpos_q      <= '0;
      lfsr_q      <= LFSR_SEED;
      count_q     <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wpos_q      <= wpos_d;
      whalf_q     <= whalf_d;
      ppos_q      <= ppos_d;
      phalf_q     <= phalf_d;
      bpos_q      <= bpos_d;
      lfsr_q      <= lfsr_d;
      count_q     <= count_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sel_q    <= sel_d;
    fixed_q  <= fixed_d;
    parity_q <= parity_d;
    if (ctl_i.resp_go) begin
      out_data_q <= {src_byte, half_byte};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/mic_sample_serializer.sv =====
// top level of the mic sample serializer: config registers, controller and datapath
//
// Command words enter on the s_axis channel: tuser carries the command
// (read, capture, load, reset), tdata the byte and the button and
// load-first flags. Only a read gives a result word on m_axis: the
// serialized half of the source byte in the low byte of tdata and the
// full source byte in the high byte.
// A read's result passes the store read register, loaded at the accept
// edge, and then the output register, loaded in the response state;
// capture, load and disabled reset words return to idle at once, so the
// block takes one word every cycle for those commands while the output
// register is free, and a read holds off the next word for the response state.
// After reset, and after an enabled reset command, a silence sweep writes
// 0x80 to all 8192 capture entries, one per cycle; s_axis_tready stays
// low until the sweep ends. Config writes over APB are taken at any time.
// When the receiver stalls, the result waits in the output register and
// one more word is accepted only if the register drains in that cycle.
module mic_sample_serializer import mss_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // s_axis: tdata = data_byte[7:0], button_pressed[8], load_first[9], zero[15:10]
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // s_axis: tuser = cmd[1:0]
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  // m_axis: tdata = mic_value[7:0], display_value[15:8]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // apb config port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready
);

  mss_cfg_t cfg_q;
  mss_ctl_t ctl;
  mss_sts_t sts;
  mss_reg_e reg_idx;
  logic     cfg_we;

  assign pready  = 1'b1;
  assign reg_idx = mss_reg_e'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mic_enabled  <= 1'b1;
      cfg_q.noise_mode   <= 1'b0;
      cfg_q.movie_active <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_MIC_ENABLED:  cfg_q.mic_enabled  <= pwdata[0];
        REG_NOISE_MODE:   cfg_q.noise_mode   <= pwdata[0];
        REG_MOVIE_ACTIVE: cfg_q.movie_active <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // config readback
  always_comb begin
    unique case (reg_idx)
      REG_MIC_ENABLED:  prdata = APB_DW'(cfg_q.mic_enabled);
      REG_NOISE_MODE:   prdata = APB_DW'(cfg_q.noise_mode);
      REG_MOVIE_ACTIVE: prdata = APB_DW'(cfg_q.movie_active);
      default:          prdata = '0;
    endcase
  end

  mss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready),
    .ctl_o      (ctl)
  );

  mss_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .ctl_i       (ctl),
    .in_data_i   (s_axis_tdata[9:0]),
    .in_user_i   (s_axis_tuser),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .sts_o       (sts)
  );

  // no word is taken during the silence sweep
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.clear_run |-> !s_axis_tready)
    else $error("word accepted during capture clear");

  // an accepted read shows its result once the response state has loaded the output register
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_READ) |=> ##1 m_axis_tvalid)
    else $error("read result missing");

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.resp_go |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output register overwritten");

endmodule
